>>> design/ipv4rf_pkg.sv
package ipv4rf_pkg;

    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_NOT_IPV4  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_SUM   = 3'd3;
    localparam logic [2:0] VERDICT_NOT_OURS  = 3'd4;

    localparam logic [5:0] POS_MAC_FIRST     = 6'd6;
    localparam logic [5:0] POS_MAC_LAST      = 6'd11;
    localparam logic [5:0] POS_TYPE_HIGH     = 6'd12;
    localparam logic [5:0] POS_TYPE_LOW      = 6'd13;
    localparam logic [5:0] POS_HEADER_START  = 6'd14;
    localparam logic [5:0] POS_PROTOCOL      = 6'd23;
    localparam logic [5:0] POS_SUM_HIGH      = 6'd24;
    localparam logic [5:0] POS_SUM_LOW       = 6'd25;
    localparam logic [5:0] POS_SOURCE_FIRST  = 6'd26;
    localparam logic [5:0] POS_SOURCE_LAST   = 6'd29;
    localparam logic [5:0] POS_DEST_FIRST    = 6'd30;
    localparam logic [5:0] POS_MIN_FRAME     = 6'd34;
    localparam logic [5:0] POS_MAX           = 6'd63;

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [15:0] WORD_MASK        = 16'hFFFF;

    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'h0A00_020F;
    localparam logic [31:0] SUBNET_MASK_RESET   = 32'hFFFF_FF00;

    localparam logic REG_LOCAL_ADDRESS = 1'b0;
    localparam logic REG_SUBNET_MASK   = 1'b1;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
        logic [47:0] sender_mac;
        logic        learn_sender;
    } result_t;

    typedef struct packed {
        logic [31:0] local_address;
        logic [31:0] subnet_mask;
    } config_t;

endpackage

>>> design/ipv4rf_cfg_regs.sv
module ipv4rf_cfg_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ipv4rf_pkg::config_t  cfg
);

    logic [31:0] local_address_reg;
    logic [31:0] subnet_mask_reg;
    logic        write_en;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= ipv4rf_pkg::LOCAL_ADDRESS_RESET;
            subnet_mask_reg   <= ipv4rf_pkg::SUBNET_MASK_RESET;
        end
        else if (write_en)
        begin
            case (paddr[2])
                ipv4rf_pkg::REG_LOCAL_ADDRESS: local_address_reg <= pwdata;
                ipv4rf_pkg::REG_SUBNET_MASK:   subnet_mask_reg   <= pwdata;
                default:                       local_address_reg <= local_address_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ipv4rf_pkg::REG_LOCAL_ADDRESS: prdata = local_address_reg;
            ipv4rf_pkg::REG_SUBNET_MASK:   prdata = subnet_mask_reg;
            default:                       prdata = '0;
        endcase
    end

    assign cfg.local_address = local_address_reg;
    assign cfg.subnet_mask   = subnet_mask_reg;

endmodule

>>> design/ipv4rf_frame_parser.sv
module ipv4rf_frame_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           frame_byte,
    input  logic                 last_byte,
    input  ipv4rf_pkg::config_t  cfg,
    output ipv4rf_pkg::result_t  result
);

    logic [5:0]  position_reg, position_next;
    logic [19:0] sum_reg, sum_next;
    logic [7:0]  pending_reg, pending_next;
    logic [15:0] received_sum_reg, received_sum_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;
    logic [7:0]  protocol_reg, protocol_next;

    logic [16:0] fold_first;
    logic [16:0] fold_second;
    logic [15:0] folded;
    logic        in_header;

    always_comb
    begin
        position_next     = position_reg;
        sum_next          = sum_reg;
        pending_next      = pending_reg;
        received_sum_next = received_sum_reg;
        ether_type_next   = ether_type_reg;
        mac_next          = mac_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        protocol_next     = protocol_reg;

        if (position_reg >= ipv4rf_pkg::POS_MAC_FIRST && position_reg <= ipv4rf_pkg::POS_MAC_LAST)
        begin
            mac_next = {mac_reg[39:0], frame_byte};
        end
        else if (position_reg == ipv4rf_pkg::POS_TYPE_HIGH
                 || position_reg == ipv4rf_pkg::POS_TYPE_LOW)
        begin
            ether_type_next = {ether_type_reg[7:0], frame_byte};
        end

        in_header = position_reg >= ipv4rf_pkg::POS_HEADER_START
                    && position_reg < ipv4rf_pkg::POS_MIN_FRAME;

        if (in_header)
        begin
            if (position_reg == ipv4rf_pkg::POS_PROTOCOL)
            begin
                protocol_next = frame_byte;
            end
            else if (position_reg >= ipv4rf_pkg::POS_SOURCE_FIRST
                     && position_reg <= ipv4rf_pkg::POS_SOURCE_LAST)
            begin
                source_next = {source_reg[23:0], frame_byte};
            end
            else if (position_reg >= ipv4rf_pkg::POS_DEST_FIRST)
            begin
                dest_next = {dest_reg[23:0], frame_byte};
            end

            if (position_reg == ipv4rf_pkg::POS_SUM_HIGH
                || position_reg == ipv4rf_pkg::POS_SUM_LOW)
            begin
                received_sum_next = {received_sum_reg[7:0], frame_byte};
            end
            else if (!position_reg[0])
            begin
                pending_next = frame_byte;
            end
            else
            begin
                sum_next = sum_reg + {4'd0, pending_reg, frame_byte};
            end
        end

        if (position_reg != ipv4rf_pkg::POS_MAX)
        begin
            position_next = position_reg + 6'd1;
        end
    end

    // The sum is below 2^20, so two end-around carries finish the fold.
    always_comb
    begin
        fold_first  = {1'b0, sum_next[15:0]} + {13'd0, sum_next[19:16]};
        fold_second = {1'b0, fold_first[15:0]} + {16'd0, fold_first[16]};
        folded      = ~fold_second[15:0] & ipv4rf_pkg::WORD_MASK;
    end

    always_comb
    begin
        result.source_address  = source_next;
        result.protocol_number = protocol_next;
        result.sender_mac      = mac_next;
        result.learn_sender    = 1'b0;
        if (position_reg < ipv4rf_pkg::POS_MIN_FRAME - 6'd1)
        begin
            result.verdict         = ipv4rf_pkg::VERDICT_SHORT;
            result.source_address  = '0;
            result.protocol_number = '0;
            result.sender_mac      = '0;
        end
        else if (ether_type_next != ipv4rf_pkg::ETHERTYPE_IPV4)
        begin
            result.verdict = ipv4rf_pkg::VERDICT_NOT_IPV4;
        end
        else if (folded != received_sum_next)
        begin
            result.verdict = ipv4rf_pkg::VERDICT_BAD_SUM;
        end
        else if (dest_next != cfg.local_address)
        begin
            result.verdict = ipv4rf_pkg::VERDICT_NOT_OURS;
        end
        else
        begin
            result.verdict      = ipv4rf_pkg::VERDICT_ACCEPT;
            result.learn_sender = (source_next & cfg.subnet_mask)
                                  == (cfg.local_address & cfg.subnet_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            sum_reg          <= '0;
            pending_reg      <= '0;
            received_sum_reg <= '0;
            ether_type_reg   <= '0;
            mac_reg          <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
            protocol_reg     <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                position_reg     <= '0;
                sum_reg          <= '0;
                pending_reg      <= '0;
                received_sum_reg <= '0;
                ether_type_reg   <= '0;
                mac_reg          <= '0;
                source_reg       <= '0;
                dest_reg         <= '0;
                protocol_reg     <= '0;
            end
            else
            begin
                position_reg     <= position_next;
                sum_reg          <= sum_next;
                pending_reg      <= pending_next;
                received_sum_reg <= received_sum_next;
                ether_type_reg   <= ether_type_next;
                mac_reg          <= mac_next;
                source_reg       <= source_next;
                dest_reg         <= dest_next;
                protocol_reg     <= protocol_next;
            end
        end
    end

endmodule

>>> design/ipv4_receive_filter_unit.sv
// A final byte is first held in the byte register and then its result is loaded into the
// result register, where it waits until it is taken.
// Throughput: one frame byte per cycle; the byte register and the result register are
// parted, so bytes keep flowing while a result waits, and only a final byte is held
// until the waiting result is taken.
// Reset (rst_n, asynchronous, active low) clears the frame state and both handshakes,
// and loads local_address 10.0.2.15 and subnet_mask 255.255.255.0.
module ipv4_receive_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  verdict,
    output logic [31:0] source_address,
    output logic [7:0]  protocol_number,
    output logic [47:0] sender_mac,
    output logic        learn_sender
);

    ipv4rf_pkg::config_t cfg;
    ipv4rf_pkg::result_t parsed;
    ipv4rf_pkg::result_t result_reg;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;
    logic       result_valid_reg;
    logic       advance;

    ipv4rf_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipv4rf_frame_parser u_frame_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .frame_byte (hold_byte_reg),
        .last_byte  (hold_last_reg),
        .cfg        (cfg),
        .result     (parsed)
    );

    assign advance    = hold_valid_reg
                        && !(hold_last_reg && result_valid_reg && result_stall);
    assign byte_stall = hold_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            hold_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            hold_byte_reg <= frame_byte;
            hold_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && hold_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_last_reg)
        begin
            result_reg <= parsed;
        end
    end

    assign result_valid    = result_valid_reg;
    assign verdict         = result_reg.verdict;
    assign source_address  = result_reg.source_address;
    assign protocol_number = result_reg.protocol_number;
    assign sender_mac      = result_reg.sender_mac;
    assign learn_sender    = result_reg.learn_sender;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid_reg && result_stall && hold_last_reg)
        else $error("Input stalled while the result register could take a transaction.");

    a_learn_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && learn_sender |-> verdict == ipv4rf_pkg::VERDICT_ACCEPT)
        else $error("Sender learning flagged on a rejected frame.");

    a_short_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && verdict == ipv4rf_pkg::VERDICT_SHORT
        |-> sender_mac == '0 && source_address == '0 && protocol_number == '0)
        else $error("Short frame result carries captured fields.");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(advance && hold_last_reg))
        else $error("Result raised without a final byte.");

endmodule

>>> sim/ipv4_receive_filter_unit_tb.sv
`timescale 1ns / 100ps

module ipv4_receive_filter_unit_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  frame_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  verdict;
    logic [31:0] source_address;
    logic [7:0]  protocol_number;
    logic [47:0] sender_mac;
    logic        learn_sender;

    frame_item_t         pending_bytes [$];
    ipv4rf_pkg::result_t expected_verdicts [$];
    frame_item_t         next_item;
    ipv4rf_pkg::result_t front_verdict;
    logic                byte_accepted = 1'b0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int results_checked = 0;
    int total_items = 0;
    int total_frames = 0;
    int settings_count = 1;
    int verdict_seen [5];

    logic [31:0] cfg_local = ipv4rf_pkg::LOCAL_ADDRESS_RESET;
    logic [31:0] cfg_mask = ipv4rf_pkg::SUBNET_MASK_RESET;

    logic [5:0]  frame_pos = '0;
    logic [19:0] header_sum = '0;
    logic [7:0]  high_byte = '0;
    logic [15:0] carried_sum = '0;
    logic [15:0] frame_type = '0;
    logic [47:0] frame_mac = '0;
    logic [31:0] frame_source = '0;
    logic [31:0] frame_dest = '0;
    logic [7:0]  frame_protocol = '0;

    ipv4_receive_filter_unit u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .verdict         (verdict),
        .source_address  (source_address),
        .protocol_number (protocol_number),
        .sender_mac      (sender_mac),
        .learn_sender    (learn_sender)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] fold_complement(input logic [19:0] total);
        logic [19:0] folded;
        folded = total;
        while (folded[19:16] != 4'd0)
        begin
            folded = {4'd0, folded[15:0]} + {16'd0, folded[19:16]};
        end
        return ~folded[15:0];
    endfunction

    task automatic filter_byte(input logic [7:0] b, input logic last);
        logic [5:0]          p;
        ipv4rf_pkg::result_t r;
        p = frame_pos;
        if (p >= ipv4rf_pkg::POS_MAC_FIRST && p <= ipv4rf_pkg::POS_MAC_LAST)
            frame_mac = {frame_mac[39:0], b};
        else if (p == ipv4rf_pkg::POS_TYPE_HIGH || p == ipv4rf_pkg::POS_TYPE_LOW)
            frame_type = {frame_type[7:0], b};
        if (p >= ipv4rf_pkg::POS_HEADER_START && p < ipv4rf_pkg::POS_MIN_FRAME)
        begin
            if (p == ipv4rf_pkg::POS_PROTOCOL)
                frame_protocol = b;
            else if (p >= ipv4rf_pkg::POS_SOURCE_FIRST && p <= ipv4rf_pkg::POS_SOURCE_LAST)
                frame_source = {frame_source[23:0], b};
            else if (p >= ipv4rf_pkg::POS_DEST_FIRST)
                frame_dest = {frame_dest[23:0], b};
            if (p == ipv4rf_pkg::POS_SUM_HIGH || p == ipv4rf_pkg::POS_SUM_LOW)
                carried_sum = {carried_sum[7:0], b};
            else if (p[0] == 1'b0)
                high_byte = b;
            else
                header_sum = header_sum + {4'd0, high_byte, b};
        end
        if (frame_pos < ipv4rf_pkg::POS_MAX)
            frame_pos = frame_pos + 6'd1;
        if (last)
        begin
            r = '0;
            if (p < ipv4rf_pkg::POS_MIN_FRAME - 6'd1)
            begin
                r.verdict = ipv4rf_pkg::VERDICT_SHORT;
            end
            else
            begin
                if (frame_type != ipv4rf_pkg::ETHERTYPE_IPV4)
                    r.verdict = ipv4rf_pkg::VERDICT_NOT_IPV4;
                else if (fold_complement(header_sum) != carried_sum)
                    r.verdict = ipv4rf_pkg::VERDICT_BAD_SUM;
                else if (frame_dest != cfg_local)
                    r.verdict = ipv4rf_pkg::VERDICT_NOT_OURS;
                else
                begin
                    r.verdict = ipv4rf_pkg::VERDICT_ACCEPT;
                    r.learn_sender = ((frame_source & cfg_mask) == (cfg_local & cfg_mask));
                end
                r.source_address = frame_source;
                r.protocol_number = frame_protocol;
                r.sender_mac = frame_mac;
            end
            expected_verdicts.push_back(r);
            frame_pos = '0;
            header_sum = '0;
            high_byte = '0;
            carried_sum = '0;
            frame_type = '0;
            frame_mac = '0;
            frame_source = '0;
            frame_dest = '0;
            frame_protocol = '0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        pending_bytes.push_back({data, last});
        total_items++;
        if (last)
            total_frames++;
    endtask

    task automatic queue_noise_frame();
        int len;
        int i;
        len = $urandom_range(70, 1);
        for (i = 0; i < len; i++)
            queue_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic queue_ipv4_frame();
        logic [7:0]  frame_q [$];
        logic [31:0] dst;
        logic [31:0] src;
        logic [15:0] etype;
        logic [15:0] csum;
        logic [19:0] total;
        int          len;
        int          i;
        i = $urandom_range(99);
        if (i < 70)
            dst = cfg_local;
        else if (i < 80)
            dst = cfg_local ^ (32'd1 << $urandom_range(31));
        else
            dst = $urandom;
        if ($urandom_range(1) == 0)
            src = (cfg_local & cfg_mask) | ($urandom & ~cfg_mask);
        else
            src = $urandom;
        etype = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                         : ipv4rf_pkg::ETHERTYPE_IPV4;
        for (i = 0; i < 12; i++)
            frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);
        frame_q.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h45);
        for (i = 0; i < 9; i++)
            frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        for (i = 3; i >= 0; i--)
            frame_q.push_back(src[8*i +: 8]);
        for (i = 3; i >= 0; i--)
            frame_q.push_back(dst[8*i +: 8]);
        total = '0;
        for (i = ipv4rf_pkg::POS_HEADER_START; i < ipv4rf_pkg::POS_MIN_FRAME; i += 2)
            total = total + {4'd0, frame_q[i], frame_q[i+1]};
        csum = fold_complement(total);
        if ($urandom_range(9) == 0)
            csum = csum ^ (16'd1 << $urandom_range(15));
        frame_q[ipv4rf_pkg::POS_SUM_HIGH] = csum[15:8];
        frame_q[ipv4rf_pkg::POS_SUM_LOW] = csum[7:0];
        i = $urandom_range(19);
        if (i == 0)
            len = $urandom_range(33, 1);
        else if (i < 3)
            len = $urandom_range(100, 64);
        else
            len = $urandom_range(46, 34);
        while (frame_q.size() < len)
            frame_q.push_back(8'($urandom_range(255)));
        for (i = 0; i < len; i++)
            queue_byte(frame_q[i], i == len - 1);
    endtask

    task automatic apb_write(input logic reg_index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_index == ipv4rf_pkg::REG_LOCAL_ADDRESS)
            cfg_local = value;
        else
            cfg_mask = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_filter();
        while (pending_bytes.size() != 0 || byte_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_accepted <= byte_valid && !byte_stall;
            if (byte_valid && !byte_stall)
                filter_byte(frame_byte, last_byte);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (byte_accepted || !byte_valid))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_item = pending_bytes.pop_front();
                byte_valid <= 1'b1;
                frame_byte <= next_item.data;
                last_byte <= next_item.last;
            end
            else
            begin
                byte_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("Result transaction with no frame outstanding, verdict %0d", verdict);
                error_count++;
            end
            else
            begin
                front_verdict = expected_verdicts.pop_front();
                results_checked++;
                if (verdict < 3'd5)
                    verdict_seen[verdict]++;
                if (verdict !== front_verdict.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", front_verdict.verdict, verdict);
                    error_count++;
                end
                if (source_address !== front_verdict.source_address)
                begin
                    $error("source_address: expected %h, actual %h",
                           front_verdict.source_address, source_address);
                    error_count++;
                end
                if (protocol_number !== front_verdict.protocol_number)
                begin
                    $error("protocol_number: expected %h, actual %h",
                           front_verdict.protocol_number, protocol_number);
                    error_count++;
                end
                if (sender_mac !== front_verdict.sender_mac)
                begin
                    $error("sender_mac: expected %h, actual %h",
                           front_verdict.sender_mac, sender_mac);
                    error_count++;
                end
                if (learn_sender !== front_verdict.learn_sender)
                begin
                    $error("learn_sender: expected %0d, actual %0d",
                           front_verdict.learn_sender, learn_sender);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int phase_items;
        int i;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 7; phase++)
        begin
            if (phase <= 2)
            begin
                sender_idle_pct = 9;
                receiver_stall_pct = 65;
            end
            else if (phase <= 4)
            begin
                sender_idle_pct = 65;
                receiver_stall_pct = 9;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            case (phase)
                1:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, $urandom);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK, 32'hFFFF_FFFF);
                end
                2:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, 32'h0000_0000);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK, 32'h0000_0000);
                end
                3:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK,
                              32'hFFFF_FFFF << $urandom_range(32));
                end
                4:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, $urandom);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK, $urandom);
                end
                5:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, ipv4rf_pkg::LOCAL_ADDRESS_RESET);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK, ipv4rf_pkg::SUBNET_MASK_RESET);
                end
                6:
                begin
                    apb_write(ipv4rf_pkg::REG_LOCAL_ADDRESS, $urandom);
                    apb_write(ipv4rf_pkg::REG_SUBNET_MASK,
                              32'hFFFF_FFFF << $urandom_range(32));
                end
                default:
                begin
                end
            endcase
            if (phase != 0)
                settings_count++;
            phase_items = total_items;
            if (phase == 0)
            begin
                // Single-byte frames at both byte extremes, then a short frame that
                // carries the IPv4 ethertype but ends inside the header.
                queue_byte(8'hFF, 1'b1);
                queue_byte(8'h00, 1'b1);
                for (i = 0; i < 23; i++)
                begin
                    if (i == ipv4rf_pkg::POS_TYPE_HIGH)
                        queue_byte(ipv4rf_pkg::ETHERTYPE_IPV4[15:8], 1'b0);
                    else if (i == ipv4rf_pkg::POS_TYPE_LOW)
                        queue_byte(ipv4rf_pkg::ETHERTYPE_IPV4[7:0], 1'b0);
                    else
                        queue_byte(8'hFF, i == 22);
                end
            end
            while (total_items - phase_items < 220)
            begin
                if ($urandom_range(4) == 0)
                    queue_noise_frame();
                else
                    queue_ipv4_frame();
            end
            drain_filter();
        end
        $display("Checked %0d verdicts from %0d frame bytes in %0d frames over %0d settings.",
                 results_checked, total_items, total_frames, settings_count);
        $display("Accepted %0d, short %0d, not IPv4 %0d, bad checksum %0d, not ours %0d.",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4]);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> ipv4_receive_filter_unit.f
design/ipv4rf_pkg.sv
design/ipv4rf_cfg_regs.sv
design/ipv4rf_frame_parser.sv
design/ipv4_receive_filter_unit.sv
sim/ipv4_receive_filter_unit_tb.sv
